// ===== design/csim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package csim_pkg;

  localparam int unsigned MAX_PAIRS = 4096;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned SUM_W     = 60;
  localparam int unsigned DOT_W     = 61;
  localparam int unsigned PROD_W    = 2 * SUM_W;
  localparam int unsigned HALF_W    = SUM_W / 2;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned Q_W       = 31;

  // controller step counts (last index of each phase)
  localparam int unsigned MUL_LAST  = 4;
  localparam int unsigned ROOT_LAST = SUM_W - 1;
  localparam int unsigned DIV_LAST  = 30;

  localparam logic [31:0] SIM_MINUS_TWO = 32'h8000_0000;
  localparam logic [Q_W-1:0] Q_ONE      = 31'h4000_0000;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_ODD  = 3'd1,
    ST_TYPE = 3'd2,
    ST_NORM = 3'd3,
    ST_LONG = 3'd4
  } status_e;

  typedef struct packed {
    logic       accept;
    logic       check;
    logic       emit_early;
    logic       mul_issue;
    logic [1:0] mul_idx;
    logic       root_step;
    logic       div_step;
    logic       div_first;
    logic       emit_final;
  } cmd_t;

  typedef struct packed {
    logic early;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/csim_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module csim_ctrl
  import csim_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start_i,
  input  wire   last_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FLUSH = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_ROOT  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (last_i) state_d = S_FLUSH;
        end
      end
      S_FLUSH: state_d = S_CHECK;
      S_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d = '0;
        if (sts_i.early) begin
          cmd_o.emit_early = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // four partial products, then a final step with no issue to drain the adder
        cmd_o.mul_issue = (cnt_q < STEP_W'(MUL_LAST));
        cmd_o.mul_idx   = cnt_q[1:0];
        if (cnt_q == STEP_W'(MUL_LAST)) begin
          cnt_d = '0;
          state_d = S_ROOT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == STEP_W'(ROOT_LAST)) begin
          cnt_d = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        if (cnt_q == STEP_W'(DIV_LAST)) begin
          cnt_d = '0;
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.emit_final = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/csim_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module csim_dp
  import csim_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  wire signed [VAL_W-1:0]  x_value_i,
  input  wire signed [VAL_W-1:0]  y_value_i,
  input  wire                     not_numeric_i,
  input  wire                     unpaired_i,
  input  wire                     last_i,
  input  wire                     cfg_we_i,
  input  wire [SUM_W-1:0]         cfg_wdata_i,
  output logic signed [31:0]      similarity_o,
  output logic [2:0]              status_o,
  output logic                    done_o
);

  logic [SUM_W-1:0]         eps_q;
  logic signed [DOT_W-1:0]  dot_q, dot_d;
  logic [SUM_W-1:0]         xn_q, xn_d, yn_q, yn_d;
  logic                     type_q, type_d, odd_q, odd_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     acc_q, acc_d;
  logic signed [2*VAL_W-1:0] pxy_q, pxx_q, pyy_q;
  logic signed [2*VAL_W-1:0] pxy, pxx, pyy;
  logic                     take;

  logic [2*HALF_W-1:0]      pp_q, pp_d;
  logic [1:0]               sh_q, sh_d;
  logic                     ppv_q;
  logic [HALF_W-1:0]        a_h, b_h;
  logic [PROD_W-1:0]        prod_q, prod_d, pp_ext;
  logic [SUM_W:0]           rem_q, rem_d;
  logic [SUM_W-1:0]         root_q, root_d;
  logic [SUM_W+2:0]         rem_t, trial;
  logic [DOT_W-1:0]         r_q, r_d;
  logic [DOT_W:0]           dt, s_ext;
  logic                     ge;
  logic [Q_W-1:0]           q_q, q_d, mag;
  logic                     neg_q, neg_d, sat_q, sat_d;

  status_e                  early;
  logic                     emit;
  logic signed [31:0]       sim_d;
  status_e                  stat_d;

  assign pxy = x_value_i * y_value_i;
  assign pxx = x_value_i * x_value_i;
  assign pyy = y_value_i * y_value_i;

  // a stray unpaired mark without last is dropped
  assign take = cmd_i.accept && !(unpaired_i && !last_i);
  assign emit = cmd_i.emit_early || cmd_i.emit_final;

  always_comb begin
    if (odd_q)                                early = ST_ODD;
    else if (cnt_q > CNT_W'(MAX_PAIRS))       early = ST_LONG;
    else if (type_q)                          early = ST_TYPE;
    else if (xn_q <= eps_q || yn_q <= eps_q)  early = ST_NORM;
    else                                      early = ST_OK;
  end
  assign sts_o.early = (early != ST_OK);

  always_comb begin
    dot_d  = dot_q;
    xn_d   = xn_q;
    yn_d   = yn_q;
    type_d = type_q;
    odd_d  = odd_q;
    cnt_d  = cnt_q;
    acc_d  = 1'b0;
    if (acc_q) begin
      dot_d = dot_q + DOT_W'(pxy_q);
      xn_d  = xn_q + SUM_W'(unsigned'(pxx_q));
      yn_d  = yn_q + SUM_W'(unsigned'(pyy_q));
    end
    if (take) begin
      if (unpaired_i) begin
        odd_d = 1'b1;
      end else if (cnt_q >= CNT_W'(MAX_PAIRS)) begin
        cnt_d = CNT_W'(MAX_PAIRS + 1);
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (not_numeric_i) type_d = 1'b1;
        else               acc_d  = 1'b1;
      end
    end
    if (emit) begin
      dot_d  = '0;
      xn_d   = '0;
      yn_d   = '0;
      type_d = 1'b0;
      odd_d  = 1'b0;
      cnt_d  = '0;
    end
  end

  // norm product from 30x30 partial products
  assign a_h  = cmd_i.mul_idx[1] ? xn_q[SUM_W-1:HALF_W] : xn_q[HALF_W-1:0];
  assign b_h  = cmd_i.mul_idx[0] ? yn_q[SUM_W-1:HALF_W] : yn_q[HALF_W-1:0];
  assign pp_d = a_h * b_h;
  assign sh_d = {1'b0, cmd_i.mul_idx[1]} + {1'b0, cmd_i.mul_idx[0]};

  always_comb begin
    unique case (sh_q)
      2'd0:    pp_ext = PROD_W'(pp_q);
      2'd1:    pp_ext = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
      2'd2:    pp_ext = {pp_q, {(2*HALF_W){1'b0}}};
      default: pp_ext = '0;
    endcase
  end

  // digit-by-digit square root, two product bits per step
  assign rem_t = {rem_q, prod_q[PROD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.check) begin
      prod_d = '0;
      rem_d  = '0;
      root_d = '0;
    end else if (ppv_q) begin
      prod_d = prod_q + pp_ext;
    end else if (cmd_i.root_step) begin
      prod_d = {prod_q[PROD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_d  = (SUM_W+1)'(rem_t - trial);
        root_d = {root_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d  = (SUM_W+1)'(rem_t);
        root_d = {root_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  // restoring division of |dot| by the root
  assign dt    = cmd_i.div_first ? {1'b0, r_q} : {r_q, 1'b0};
  assign s_ext = {2'b00, root_q};
  assign ge    = (dt >= s_ext);

  always_comb begin
    r_d   = r_q;
    q_d   = q_q;
    neg_d = neg_q;
    sat_d = sat_q;
    if (cmd_i.check) begin
      neg_d = dot_q[DOT_W-1];
      r_d   = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
      q_d   = '0;
      sat_d = 1'b0;
    end else if (cmd_i.div_step) begin
      if (cmd_i.div_first) sat_d = (dt >= {1'b0, root_q, 1'b0});
      r_d = ge ? DOT_W'(dt - s_ext) : DOT_W'(dt);
      q_d = {q_q[Q_W-2:0], ge};
    end
  end

  assign mag = (sat_q || q_q > Q_ONE) ? Q_ONE : q_q;

  always_comb begin
    sim_d  = '0;
    stat_d = ST_OK;
    if (cmd_i.emit_early) begin
      stat_d = early;
      sim_d  = (early == ST_TYPE) ? 32'sd0 : signed'(SIM_MINUS_TWO);
    end else begin
      sim_d  = neg_q ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q  <= '0;
      dot_q  <= '0;
      xn_q   <= '0;
      yn_q   <= '0;
      type_q <= 1'b0;
      odd_q  <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= 1'b0;
      ppv_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      if (cfg_we_i) eps_q <= cfg_wdata_i;
      dot_q  <= dot_d;
      xn_q   <= xn_d;
      yn_q   <= yn_d;
      type_q <= type_d;
      odd_q  <= odd_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      ppv_q  <= cmd_i.mul_issue;
      done_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pxy_q <= pxy;
      pxx_q <= pxx;
      pyy_q <= pyy;
    end
    pp_q   <= pp_d;
    sh_q   <= sh_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    r_q    <= r_d;
    q_q    <= q_d;
    neg_q  <= neg_d;
    sat_q  <= sat_d;
    if (emit) begin
      similarity_o <= sim_d;
      status_o     <= stat_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/cosine_similarity_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming cosine similarity. While busy_o is low one (x, y) pair is taken
// per cycle; each pair is squared and multiplied, the products are registered
// and added to the sums in the next cycle. After a request marked last, busy_o
// stays high while the result is formed: a flush state and a check state,
// then, only when no error applies, the 60x60 norm product (four 30x30 partial
// products), the two-bit-per-step square root, the restoring divider and a
// final state that loads the result. The result is registered on
// similarity_o / status_o with done_o high for exactly one cycle and must be
// taken then; there is no back pressure. The user must write epsilon through
// cfg_we_i / cfg_wdata_i only while the block is idle; the block itself does
// not enforce this.
module cosine_similarity_engine
  import csim_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  output logic                    busy_o,
  input  wire signed [VAL_W-1:0]  x_value_i,
  input  wire signed [VAL_W-1:0]  y_value_i,
  input  wire                     not_numeric_i,
  input  wire                     unpaired_i,
  input  wire                     last_i,
  input  wire                     cfg_we_i,
  input  wire [SUM_W-1:0]         cfg_wdata_i,
  output logic signed [31:0]      similarity_o,
  output logic [2:0]              status_o,
  output logic                    done_o
);

  cmd_t cmd;
  sts_t sts;

  csim_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .last_i  (last_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  csim_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .x_value_i     (x_value_i),
    .y_value_i     (y_value_i),
    .not_numeric_i (not_numeric_i),
    .unpaired_i    (unpaired_i),
    .last_i        (last_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .similarity_o  (similarity_o),
    .status_o      (status_o),
    .done_o        (done_o)
  );

endmodule
`default_nettype wire
